// ----- src/aws_pkg.sv -----
package aws_pkg;

   localparam int PATTERN_MAX_DEF   = 64;
   localparam int ALPHABET_DEF      = 256;
   localparam int POSITION_BITS_DEF = 16;

   localparam int SYMBOL_W = 8;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NEW     = 2'd0,
      ACT_PATTERN = 2'd1,
      ACT_TEXT    = 2'd2,
      ACT_END     = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_MATCH    = 2'd0,
      ST_NO_MATCH = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      action_type            op;
      logic [SYMBOL_W-1:0]   sym;
   } item_type;

endpackage

// ----- src/aws_front.sv -----
module aws_front #(
   parameter int ALPHABET = aws_pkg::ALPHABET_DEF
) (
   input  logic                          in_valid,
   input  logic                          in_ready,
   input  logic [aws_pkg::ACTION_W-1:0]  in_action,
   input  logic [aws_pkg::SYMBOL_W-1:0]  in_symbol,
   output logic                          push,
   output aws_pkg::item_type             item
);

   localparam logic [aws_pkg::SYMBOL_W:0] SYM_LIMIT = (aws_pkg::SYMBOL_W + 1)'(ALPHABET);

   aws_pkg::action_type op;
   logic                in_range;
   logic                keep;

   assign op       = aws_pkg::action_type'(in_action);
   assign in_range = {1'b0, in_symbol} < SYM_LIMIT;

   // pattern and text symbols outside the alphabet leave no trace, so they never reach the queue
   always_comb begin
      case (op)
         aws_pkg::ACT_NEW:     keep = 1'b1;
         aws_pkg::ACT_END:     keep = 1'b1;
         aws_pkg::ACT_PATTERN: keep = in_range;
         aws_pkg::ACT_TEXT:    keep = in_range;
         default:              keep = 1'b0;
      endcase
   end

   assign push     = in_valid && in_ready && keep;
   assign item.op  = op;
   assign item.sym = in_symbol;

endmodule

// ----- src/aws_queue.sv -----
module aws_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  aws_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output aws_pkg::item_type head_item
);

   localparam int PTR_W = $clog2(aws_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(aws_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(aws_pkg::QUEUE_DEPTH);

   aws_pkg::item_type slots [aws_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == CNT_FULL;
   assign head_valid = count_ff != '0;
   assign head_item  = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- src/aws_back.sv -----
module aws_back #(
   parameter int PATTERN_MAX   = aws_pkg::PATTERN_MAX_DEF,
   parameter int ALPHABET      = aws_pkg::ALPHABET_DEF,
   parameter int POSITION_BITS = aws_pkg::POSITION_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  aws_pkg::item_type          head_item,
   output logic                       pop,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output aws_pkg::status_type        rsp_status,
   output logic [POSITION_BITS-1:0]   rsp_position
);

   localparam int ADDR_W = $clog2(ALPHABET);
   localparam int PL_W   = $clog2(PATTERN_MAX + 1);
   localparam int SLOT_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int HIST_W = PL_W + 1;
   localparam int TC_W   = POSITION_BITS + 1;
   localparam int CMP_W  = (TC_W > PL_W) ? TC_W : PL_W;

   localparam logic [PL_W-1:0]   PL_MAX    = PL_W'(PATTERN_MAX);
   localparam logic [PL_W:0]     PM_EXT    = (PL_W + 1)'(PATTERN_MAX);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PATTERN_MAX - 1);
   localparam logic [TC_W-1:0]   TC_LIMIT  = {1'b1, {POSITION_BITS{1'b0}}};

   typedef enum logic [1:0] {
      W_PAT_INC,
      W_TXT_DEC,
      W_TXT_INC
   } wop_type;

   // histogram and window line
   logic [HIST_W-1:0] hist_mem [ALPHABET];
   logic [ALPHABET-1:0] hvalid_ff;
   logic [HIST_W-1:0] hist_rd_ff;
   logic              hvalid_rd_ff;
   logic              byp_ff;
   logic [HIST_W-1:0] byp_data_ff;

   logic [ADDR_W-1:0] dl_mem [PATTERN_MAX];
   logic [ADDR_W-1:0] dl_rd_ff;

   // search state
   logic [PL_W-1:0]          pl_ff, pl_in;
   logic [TC_W-1:0]          tc_ff, tc_in;
   logic [SLOT_W-1:0]        ws_ff, ws_in;
   logic [PL_W-1:0]          missing_ff, missing_in;
   logic                     reported_ff, reported_in;
   logic                     overflow_ff, overflow_in;
   logic                     phase_ff, phase_in;
   logic [POSITION_BITS-1:0] leave_pos_ff, leave_pos_in;

   // update stage
   logic                     w_valid_ff, w_valid_in;
   wop_type                  w_op_ff, w_op_in;
   logic [ADDR_W-1:0]        w_addr_ff, w_addr_in;
   logic                     w_check_ff, w_check_in;
   logic [POSITION_BITS-1:0] w_pos_ff, w_pos_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   aws_pkg::status_type      rsp_status_ff, rsp_status_in;
   logic [POSITION_BITS-1:0] rsp_pos_ff, rsp_pos_in;

   logic              advance;
   logic [HIST_W-1:0] w_cur;
   logic [HIST_W-1:0] w_new;
   logic [PL_W-1:0]   miss_w;
   logic              w_match;
   logic              rep_fwd;

   logic [ADDR_W-1:0]        sym_a;
   logic [TC_W-1:0]          tc_plus;
   logic [CMP_W-1:0]         pos_full;
   logic                     leave;
   logic                     after_ge;
   logic [PL_W:0]            ws_ext;
   logic [PL_W:0]            pl_ext1;
   logic [PL_W:0]            ls_full;
   logic [SLOT_W-1:0]        leave_slot;

   logic                     clear;
   logic                     issue;
   logic                     dl_we;
   logic                     r_res;
   logic                     r_report;
   aws_pkg::status_type      r_status;

   assign advance = !(rsp_valid_ff && !rsp_ready);

   // update stage: one read-modify-write result per cycle while the result register is not stalled
   always_comb begin
      w_cur  = byp_ff ? byp_data_ff : (hvalid_rd_ff ? hist_rd_ff : '0);
      w_new  = w_cur + 1'b1;
      miss_w = missing_ff;
      if (w_valid_ff) begin
         case (w_op_ff)
            W_PAT_INC: begin
               w_new  = w_cur + 1'b1;
               miss_w = missing_ff + 1'b1;
            end
            W_TXT_DEC: begin
               w_new = w_cur - 1'b1;
               if (!w_new[HIST_W-1] && missing_ff != '0) begin
                  miss_w = missing_ff - 1'b1;
               end
            end
            W_TXT_INC: begin
               w_new = w_cur + 1'b1;
               if (!w_new[HIST_W-1] && w_new != '0) begin
                  miss_w = missing_ff + 1'b1;
               end
            end
            default: begin
               w_new  = w_cur;
               miss_w = missing_ff;
            end
         endcase
      end
   end

   assign w_match = w_valid_ff && w_check_ff && miss_w == '0;
   assign rep_fwd = reported_ff || w_match;

   // issue stage helpers
   assign sym_a    = head_item.sym[ADDR_W-1:0];
   assign tc_plus  = tc_ff + 1'b1;
   assign leave    = CMP_W'(tc_ff) >= CMP_W'(pl_ff);
   assign after_ge = CMP_W'(tc_plus) >= CMP_W'(pl_ff);
   assign pos_full = CMP_W'(tc_plus) - CMP_W'(pl_ff);
   assign ws_ext   = (PL_W + 1)'(ws_ff);
   assign pl_ext1  = (PL_W + 1)'(pl_ff);
   assign ls_full  = (ws_ext >= pl_ext1) ? ws_ext - pl_ext1 : ws_ext + PM_EXT - pl_ext1;
   assign leave_slot = ls_full[SLOT_W-1:0];

   assign pop = advance && !phase_ff && head_valid;

   always_comb begin
      pl_in        = pl_ff;
      tc_in        = tc_ff;
      ws_in        = ws_ff;
      overflow_in  = overflow_ff;
      phase_in     = phase_ff;
      leave_pos_in = leave_pos_ff;
      clear        = 1'b0;
      issue        = 1'b0;
      w_op_in      = W_PAT_INC;
      w_addr_in    = sym_a;
      w_check_in   = 1'b0;
      w_pos_in     = '0;
      dl_we        = 1'b0;
      r_res        = 1'b0;
      r_report     = 1'b0;
      r_status     = aws_pkg::ST_MATCH;
      if (advance) begin
         if (phase_ff) begin
            // leaving byte of the window
            issue        = 1'b1;
            w_op_in      = W_TXT_INC;
            w_addr_in    = dl_rd_ff;
            w_check_in   = 1'b1;
            w_pos_in     = leave_pos_ff;
            phase_in     = 1'b0;
         end else if (head_valid) begin
            case (head_item.op)
               aws_pkg::ACT_NEW: begin
                  clear = 1'b1;
               end
               aws_pkg::ACT_PATTERN: begin
                  if (tc_ff == '0 && !overflow_ff) begin
                     if (pl_ff >= PL_MAX) begin
                        overflow_in = 1'b1;
                     end else begin
                        issue = 1'b1;
                        pl_in = pl_ff + 1'b1;
                     end
                  end
               end
               aws_pkg::ACT_TEXT: begin
                  if (!rep_fwd && !overflow_ff) begin
                     if (pl_ff == '0) begin
                        r_res    = 1'b1;
                        r_report = 1'b1;
                     end else if (tc_ff >= TC_LIMIT) begin
                        overflow_in = 1'b1;
                     end else begin
                        issue   = 1'b1;
                        w_op_in = W_TXT_DEC;
                        dl_we   = 1'b1;
                        tc_in   = tc_plus;
                        ws_in   = (ws_ff == SLOT_LAST) ? '0 : ws_ff + 1'b1;
                        if (leave) begin
                           phase_in     = 1'b1;
                           leave_pos_in = pos_full[POSITION_BITS-1:0];
                        end else begin
                           w_check_in = after_ge;
                           w_pos_in   = pos_full[POSITION_BITS-1:0];
                        end
                     end
                  end
               end
               aws_pkg::ACT_END: begin
                  if (!rep_fwd) begin
                     r_res = 1'b1;
                     if (overflow_ff) begin
                        r_status = aws_pkg::ST_OVERFLOW;
                     end else if (pl_ff == '0) begin
                        r_report = 1'b1;
                     end else begin
                        r_status = aws_pkg::ST_NO_MATCH;
                     end
                  end
               end
               default: begin
                  clear = 1'b0;
               end
            endcase
         end
      end
   end

   always_comb begin
      w_valid_in  = advance ? issue : w_valid_ff;
      missing_in  = clear ? '0 : (advance ? miss_w : missing_ff);
      reported_in = reported_ff;
      if (clear) begin
         reported_in = 1'b0;
      end else if (advance && (w_match || r_report)) begin
         reported_in = 1'b1;
      end
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      if (advance) begin
         rsp_valid_in = w_match || r_res;
         if (w_match) begin
            rsp_status_in = aws_pkg::ST_MATCH;
            rsp_pos_in    = w_pos_ff;
         end else begin
            rsp_status_in = r_status;
            rsp_pos_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pl_ff        <= '0;
         tc_ff        <= '0;
         ws_ff        <= '0;
         missing_ff   <= '0;
         reported_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         w_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clear) begin
            pl_ff       <= '0;
            tc_ff       <= '0;
            ws_ff       <= '0;
            overflow_ff <= 1'b0;
         end else begin
            pl_ff       <= pl_in;
            tc_ff       <= tc_in;
            ws_ff       <= ws_in;
            overflow_ff <= overflow_in;
         end
         missing_ff   <= missing_in;
         reported_ff  <= reported_in;
         phase_ff     <= phase_in;
         w_valid_ff   <= w_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      leave_pos_ff  <= leave_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      if (advance && issue) begin
         w_op_ff    <= w_op_in;
         w_addr_ff  <= w_addr_in;
         w_check_ff <= w_check_in;
         w_pos_ff   <= w_pos_in;
      end
   end

   // histogram: one read and one write port
   always_ff @(posedge clock) begin
      if (advance && w_valid_ff) begin
         hist_mem[w_addr_ff] <= w_new;
      end
      if (advance && issue) begin
         hist_rd_ff  <= hist_mem[w_addr_in];
         byp_ff      <= w_valid_ff && w_addr_ff == w_addr_in;
         byp_data_ff <= w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         hvalid_ff <= '0;
      end else if (advance && w_valid_ff) begin
         hvalid_ff[w_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hvalid_rd_ff <= 1'b0;
      end else if (advance && issue) begin
         hvalid_rd_ff <= hvalid_ff[w_addr_in];
      end
   end

   // window delay line
   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[ws_ff] <= sym_a;
         dl_rd_ff      <= dl_mem[leave_slot];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_pos_ff;

endmodule

// ----- src/anagram_window_search.sv -----
// path: an end item answers via the queue and the result register; a text byte that
// completes a match passes the update stage as well (for the leaving byte when full)
// throughput: new-search, pattern and end items 1 per cycle, text bytes 1 per cycle until
// the window is full, unless the response stalls; after that each text byte holds the next
// item for the leaving byte's second read-modify-write on the single histogram write port
// reset: synchronous, clears all control state and the histogram valid bits at once
module anagram_window_search #(
   parameter int PATTERN_MAX   = aws_pkg::PATTERN_MAX_DEF,
   parameter int ALPHABET      = aws_pkg::ALPHABET_DEF,
   parameter int POSITION_BITS = aws_pkg::POSITION_BITS_DEF,
   localparam int RSP_DATA_W   = ((POSITION_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [aws_pkg::SYMBOL_W-1:0]  req_tdata,   // symbol
   input  logic [aws_pkg::ACTION_W-1:0]  req_tuser,   // action
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_DATA_W-1:0]         rsp_tdata,   // position
   output logic [aws_pkg::STATUS_W-1:0]  rsp_tuser    // status
);

   aws_pkg::item_type   push_item;
   aws_pkg::item_type   head_item;
   aws_pkg::status_type status;
   logic                push;
   logic                full;
   logic                pop;
   logic                head_valid;
   logic [POSITION_BITS-1:0] position;

   assign req_tready = !full;

   aws_front #(
      .ALPHABET (ALPHABET)
   ) u_front (
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (req_tuser),
      .in_symbol (req_tdata),
      .push      (push),
      .item      (push_item)
   );

   aws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   aws_back #(
      .PATTERN_MAX   (PATTERN_MAX),
      .ALPHABET      (ALPHABET),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .pop          (pop),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_status   (status),
      .rsp_position (position)
   );

   assign rsp_tdata = RSP_DATA_W'(position);
   assign rsp_tuser = status;

endmodule

// ----- src/aws_checker.sv -----
module aws_checker #(
   parameter int POSITION_BITS = aws_pkg::POSITION_BITS_DEF,
   localparam int RSP_DATA_W   = ((POSITION_BITS + 7) / 8) * 8
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [aws_pkg::SYMBOL_W-1:0]  req_tdata,
   input logic [aws_pkg::ACTION_W-1:0]  req_tuser,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [RSP_DATA_W-1:0]         rsp_tdata,
   input logic [aws_pkg::STATUS_W-1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != aws_pkg::ST_MATCH |-> rsp_tdata == '0)
      else $error("position set on a result that is not a match");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid && req_tready))
      else $error("input ready dropped without a transfer");

endmodule

bind anagram_window_search aws_checker #(
   .POSITION_BITS (POSITION_BITS)
) u_aws_checker (.*);
